[src/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg
// Types, widths and the arctangent table shared by the quaternion to Euler
// heading pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QFB              = 14;
    localparam int ANGLE_W          = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int LANE_W           = 35;
    localparam int CORD_W           = 54;
    localparam int SN_W             = 31;
    localparam int RAD_W            = 62;
    localparam int ISQ_STAGES       = 31;
    localparam int LANES            = 3;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] heading_angle;
        logic               gimbal_lock;
    } result_t;

    typedef struct packed {
        logic signed [SN_W-1:0]   sn;
        logic signed [LANE_W-1:0] roll_y;
        logic signed [LANE_W-1:0] roll_x;
        logic signed [LANE_W-1:0] yaw_y;
        logic signed [LANE_W-1:0] yaw_x;
        logic                     lock;
        logic                     pos;
    } side_t;

    typedef struct packed {
        logic lock;
        logic pos;
    } flags_t;

    function automatic logic [31:0] atan_tab(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10680350;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[src/qte_front.sv]
// ----------------------------------------------------------------------------
// qte_front
// Products, angle operands, singular test and the radicand for the pitch
// cosine, over three register stages.
// ----------------------------------------------------------------------------
module qte_front
    import qte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  quat_t             quat,
    output logic              out_valid,
    output logic [RAD_W-1:0]  rad,
    output side_t             side
);

    localparam logic signed [32:0] THR =
        33'((64'sd1 <<< (2*QFB-1)) - (64'sd1 <<< (2*QFB-10)));

    logic                     va_reg, vb_reg, vc_reg;
    logic signed [31:0]       ww_reg, xx_reg, yy_reg, zz_reg, wx_reg;
    logic signed [31:0]       wy_reg, xz_reg, yz_reg, xy_reg, wz_reg;
    logic signed [15:0]       qw_reg, qx_reg;
    side_t                    sb_next, sb_reg, sc_reg;
    logic signed [32:0]       t_next;
    logic signed [35:0]       s_wide;
    logic signed [2*SN_W-1:0] sq;
    logic [RAD_W-1:0]         rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ww_reg <= quat.quat_w * quat.quat_w;
        xx_reg <= quat.quat_x * quat.quat_x;
        yy_reg <= quat.quat_y * quat.quat_y;
        zz_reg <= quat.quat_z * quat.quat_z;
        wx_reg <= quat.quat_w * quat.quat_x;
        wy_reg <= quat.quat_w * quat.quat_y;
        xz_reg <= quat.quat_x * quat.quat_z;
        yz_reg <= quat.quat_y * quat.quat_z;
        xy_reg <= quat.quat_x * quat.quat_y;
        wz_reg <= quat.quat_w * quat.quat_z;
        qw_reg <= quat.quat_w;
        qx_reg <= quat.quat_x;
    end

    always_comb
    begin
        t_next = 33'(wy_reg) - 33'(xz_reg);
        s_wide = 36'(t_next) <<< (31 - 2*QFB);
        sb_next.sn     = SN_W'(s_wide);
        sb_next.lock   = (t_next > THR) || (t_next < -THR);
        sb_next.pos    = t_next > 33'sd0;
        sb_next.roll_y = (LANE_W'(yz_reg) + LANE_W'(wx_reg)) <<< 1;
        sb_next.roll_x = LANE_W'(ww_reg) - LANE_W'(xx_reg) - LANE_W'(yy_reg)
                       + LANE_W'(zz_reg);
        if (sb_next.lock)
        begin
            sb_next.yaw_y = LANE_W'(qx_reg);
            sb_next.yaw_x = LANE_W'(qw_reg);
        end
        else
        begin
            sb_next.yaw_y = (LANE_W'(xy_reg) + LANE_W'(wz_reg)) <<< 1;
            sb_next.yaw_x = LANE_W'(ww_reg) + LANE_W'(xx_reg) - LANE_W'(yy_reg)
                          - LANE_W'(zz_reg);
        end
    end

    assign sq = sb_reg.sn * sb_reg.sn;

    always_ff @(posedge clk)
    begin
        sb_reg  <= sb_next;
        sc_reg  <= sb_reg;
        rad_reg <= (RAD_W'(1) << 60) - RAD_W'(unsigned'(sq));
    end

    assign out_valid = vc_reg;
    assign rad       = rad_reg;
    assign side      = sc_reg;

endmodule

[src/qte_isqrt.sv]
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root, one result bit per stage, with the
// operands of the angle lanes carried alongside.
// ----------------------------------------------------------------------------
module qte_isqrt
    import qte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  rad,
    input  side_t             side_in,
    output logic              out_valid,
    output logic [SN_W-1:0]   root,
    output side_t             side_out
);

    logic [ISQ_STAGES-1:0] v_reg;
    logic [RAD_W-1:0]      n_reg   [ISQ_STAGES];
    logic [RAD_W-1:0]      res_reg [ISQ_STAGES];
    side_t                 s_reg   [ISQ_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[ISQ_STAGES-2:0], in_valid};
    end

    for (genvar k = 0; k < ISQ_STAGES; k++)
    begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2*(ISQ_STAGES-1-k));
        logic [RAD_W-1:0] n_in, res_in, trial, n_next, res_next;
        side_t            s_in;

        if (k == 0)
        begin : g_first
            assign n_in   = rad;
            assign res_in = '0;
            assign s_in   = side_in;
        end
        else
        begin : g_rest
            assign n_in   = n_reg[k-1];
            assign res_in = res_reg[k-1];
            assign s_in   = s_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (n_in >= trial)
            begin
                n_next   = n_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                n_next   = n_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[k]   <= n_next;
            res_reg[k] <= res_next;
            s_reg[k]   <= s_in;
        end
    end

    assign out_valid = v_reg[ISQ_STAGES-1];
    assign root      = res_reg[ISQ_STAGES-1][SN_W-1:0];
    assign side_out  = s_reg[ISQ_STAGES-1];

endmodule

[src/qte_cordic.sv]
// ----------------------------------------------------------------------------
// qte_cordic
// Three vectoring CORDIC lanes in lockstep, one rotation per stage,
// giving atan2 in 32-bit binary angle units.
// ----------------------------------------------------------------------------
module qte_cordic
    import qte_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [LANE_W-1:0] y_in [LANES],
    input  logic signed [LANE_W-1:0] x_in [LANES],
    input  flags_t                   flags_in,
    output logic                     out_valid,
    output logic [31:0]              ang_out [LANES],
    output flags_t                   flags_out
);

    logic [STEPS:0]            v_reg;
    logic signed [CORD_W-1:0]  x_reg [STEPS+1][LANES];
    logic signed [CORD_W-1:0]  y_reg [STEPS+1][LANES];
    logic [31:0]               a_reg [STEPS+1][LANES];
    flags_t                    f_reg [STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[STEPS-1:0], in_valid};
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [CORD_W-1:0] xe, ye;
        assign xe = CORD_W'(x_in[l]);
        assign ye = CORD_W'(y_in[l]);

        // fold the left half-plane onto the right
        always_ff @(posedge clk)
        begin
            if (xe < 0)
            begin
                x_reg[0][l] <= (-xe) <<< 16;
                y_reg[0][l] <= (-ye) <<< 16;
                a_reg[0][l] <= 32'h8000_0000;
            end
            else
            begin
                x_reg[0][l] <= xe <<< 16;
                y_reg[0][l] <= ye <<< 16;
                a_reg[0][l] <= '0;
            end
        end

        for (genvar k = 0; k < STEPS; k++)
        begin : g_step
            logic signed [CORD_W-1:0] dx, dy;
            assign dx = x_reg[k][l] >>> k;
            assign dy = y_reg[k][l] >>> k;

            always_ff @(posedge clk)
            begin
                if (y_reg[k][l] > 0)
                begin
                    x_reg[k+1][l] <= x_reg[k][l] + dy;
                    y_reg[k+1][l] <= y_reg[k][l] - dx;
                    a_reg[k+1][l] <= a_reg[k][l] + atan_tab(k);
                end
                else if (y_reg[k][l] < 0)
                begin
                    x_reg[k+1][l] <= x_reg[k][l] - dy;
                    y_reg[k+1][l] <= y_reg[k][l] + dx;
                    a_reg[k+1][l] <= a_reg[k][l] - atan_tab(k);
                end
                else
                begin
                    x_reg[k+1][l] <= x_reg[k][l];
                    y_reg[k+1][l] <= y_reg[k][l];
                    a_reg[k+1][l] <= a_reg[k][l];
                end
            end
        end

        assign ang_out[l] = a_reg[STEPS][l];
    end

    always_ff @(posedge clk)
    begin
        f_reg[0] <= flags_in;
        for (int k = 0; k < STEPS; k++)
            f_reg[k+1] <= f_reg[k];
    end

    assign out_valid = v_reg[STEPS];
    assign flags_out = f_reg[STEPS];

endmodule

[src/quaternion_to_euler_heading.sv]
// Throughput: one transaction per cycle; busy is held low.
// Latency comes from the front stages, the one-bit-per-stage square root, the CORDIC stages and the output register.
// Reset clears every valid bit at once; payload registers are not reset.
// The receiver cannot stall, so done lasts exactly one cycle per result.
// ----------------------------------------------------------------------------
// quaternion_to_euler_heading
// Unit quaternion to Z-Y-X Euler angles and heading, fully pipelined.
// ----------------------------------------------------------------------------
module quaternion_to_euler_heading
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  quat_t   quat,
    output logic    done,
    output result_t result
);

    logic                     f_valid, q_valid, c_valid;
    logic [RAD_W-1:0]         rad;
    side_t                    f_side, q_side;
    logic [SN_W-1:0]          root;
    logic signed [LANE_W-1:0] ly [LANES];
    logic signed [LANE_W-1:0] lx [LANES];
    logic [31:0]              ang [LANES];
    flags_t                   fl_in, fl_out;
    logic [31:0]              roll32, pitch32, yaw32;
    logic [31:0]              roll_r, pitch_r, yaw_r;
    result_t                  res_next, res_reg;
    logic                     done_reg;

    assign busy = 1'b0;

    qte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .quat     (quat),
        .out_valid(f_valid),
        .rad      (rad),
        .side     (f_side)
    );

    qte_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f_valid),
        .rad      (rad),
        .side_in  (f_side),
        .out_valid(q_valid),
        .root     (root),
        .side_out (q_side)
    );

    assign ly[0] = q_side.roll_y;
    assign lx[0] = q_side.roll_x;
    assign ly[1] = LANE_W'(q_side.sn);
    assign lx[1] = LANE_W'(root);
    assign ly[2] = q_side.yaw_y;
    assign lx[2] = q_side.yaw_x;
    assign fl_in.lock = q_side.lock;
    assign fl_in.pos  = q_side.pos;

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .y_in     (ly),
        .x_in     (lx),
        .flags_in (fl_in),
        .out_valid(c_valid),
        .ang_out  (ang),
        .flags_out(fl_out)
    );

    always_comb
    begin
        if (fl_out.lock)
        begin
            roll32  = '0;
            pitch32 = fl_out.pos ? 32'h4000_0000 : 32'hC000_0000;
            yaw32   = fl_out.pos ? (32'd0 - (ang[2] << 1)) : (ang[2] << 1);
        end
        else
        begin
            roll32  = ang[0];
            pitch32 = ang[1];
            yaw32   = ang[2];
        end
        // round half up to the output angle width
        roll_r  = roll32  + (32'd1 << (31 - ANGLE_W));
        pitch_r = pitch32 + (32'd1 << (31 - ANGLE_W));
        yaw_r   = yaw32   + (32'd1 << (31 - ANGLE_W));
        res_next.roll_angle    = roll_r[31 -: ANGLE_W];
        res_next.pitch_angle   = pitch_r[31 -: ANGLE_W];
        res_next.yaw_angle     = yaw_r[31 -: ANGLE_W];
        res_next.heading_angle = (ANGLE_W'(1) << (ANGLE_W - 2)) - yaw_r[31 -: ANGLE_W];
        res_next.gimbal_lock   = fl_out.lock;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= c_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTH
    a_lock_roll : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.gimbal_lock |-> result.roll_angle == 16'sd0)
        else $error("roll not zero in gimbal lock");

    a_lock_pitch : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.gimbal_lock |->
            result.pitch_angle == 16'sd16384 || result.pitch_angle == -16'sd16384)
        else $error("pitch not a quarter turn in gimbal lock");

    a_heading : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.heading_angle == 16'(16'sd16384 - result.yaw_angle))
        else $error("heading does not match yaw");

    a_no_busy : assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !busy)
        else $error("busy raised");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives quaternions into the Euler/heading pipeline and compares every
// result against a bit-exact fixed-point CORDIC predictor.
// ----------------------------------------------------------------------------
module testbench;
    import qte_pkg::*;

    localparam int LATENCY   = 52;
    localparam int WATCHDOG  = 4000;
    localparam int N_RANDOM  = 500;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    quat_t   quat;
    logic    done;
    result_t result;

    quat_t   pending_q[$];
    result_t angles_q[$];
    int      mismatches;
    int      idle_cycles;
    int      gap_left;
    bit      gaps_on;
    bit      hold_off;

    quaternion_to_euler_heading u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .quat   (quat),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] vector_angle(longint yv, longint xv);
        logic [31:0] ang;
        longint dx;
        longint dy;
        ang = 32'd0;
        if (xv == 0 && yv == 0)
            return 32'd0;
        if (xv < 0)
        begin
            xv  = -xv;
            yv  = -yv;
            ang = 32'h8000_0000;
        end
        xv = xv * 65536;
        yv = yv * 65536;
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shift(xv, i);
            dy = floor_shift(yv, i);
            if (yv > 0)
            begin
                xv  = xv + dy;
                yv  = yv - dx;
                ang = ang + atan_tab(i);
            end
            else if (yv < 0)
            begin
                xv  = xv - dy;
                yv  = yv + dx;
                ang = ang - atan_tab(i);
            end
            else
                break;
        end
        return ang;
    endfunction

    function automatic logic [15:0] round_angle(logic [31:0] a);
        logic [32:0] v;
        v = {1'b0, a} + 33'h8000;
        return v[31:16];
    endfunction

    function automatic result_t euler_of(quat_t q);
        result_t r;
        longint w, x, y, z, t, thr, sn;
        longint unsigned c;
        logic [31:0] a, roll32, pitch32, yaw32;
        w   = q.quat_w;
        x   = q.quat_x;
        y   = q.quat_y;
        z   = q.quat_z;
        thr = (64'sd1 << 27) - (64'sd1 << 18);
        t   = w * y - x * z;
        if (t > thr || t < -thr)
        begin
            a       = vector_angle(x, w);
            yaw32   = (t > 0) ? 32'd0 - 2 * a : 2 * a;
            pitch32 = (t > 0) ? 32'h4000_0000 : 32'hC000_0000;
            roll32  = 32'd0;
            r.gimbal_lock = 1'b1;
        end
        else
        begin
            sn      = 8 * t;
            c       = root64((64'd1 << 60) - longint'(sn * sn));
            roll32  = vector_angle(2 * (y * z + w * x), w * w - x * x - y * y + z * z);
            pitch32 = vector_angle(sn, longint'(c));
            yaw32   = vector_angle(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
            r.gimbal_lock = 1'b0;
        end
        r.roll_angle    = round_angle(roll32);
        r.pitch_angle   = round_angle(pitch32);
        r.yaw_angle     = round_angle(yaw32);
        r.heading_angle = 16'sd16384 - r.yaw_angle;
        return r;
    endfunction

    function automatic quat_t make_quat(int w, int x, int y, int z);
        quat_t q;
        q.quat_w = 16'(w);
        q.quat_x = 16'(x);
        q.quat_y = 16'(y);
        q.quat_z = 16'(z);
        return q;
    endfunction

    function automatic int comp_rand();
        return $urandom_range(32768) - 16384;
    endfunction

    // near-unit quaternion from random direction, content scaled to length one
    function automatic quat_t unit_quat(bit near_lock);
        real a, b, c, d, n;
        a = real'(comp_rand());
        b = real'(comp_rand());
        c = real'(comp_rand());
        d = real'(comp_rand());
        if (near_lock)
        begin
            c = a * (($urandom_range(1)) ? 1.0 : -1.0) + real'($urandom_range(400)) - 200.0;
            d = -b * ((c * a >= 0.0) ? 1.0 : -1.0) + real'($urandom_range(400)) - 200.0;
        end
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            return make_quat(16384, 0, 0, 0);
        return make_quat(int'(a * 16384.0 / n), int'(b * 16384.0 / n),
                         int'(c * 16384.0 / n), int'(d * 16384.0 / n));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            quat     <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                angles_q.push_back(euler_of(quat));
            if (start && busy)
            begin
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (hold_off || pending_q.size() == 0)
                start <= 1'b0;
            else if (gaps_on && $urandom_range(7) == 0)
            begin
                gap_left <= $urandom_range(10);
                start    <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                quat  <= pending_q.pop_front();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (angles_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected transaction: %p", result);
                end
                else if (result !== angles_q[0])
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch for quat: expected %p actual %p",
                                 angles_q[0], result);
                    void'(angles_q.pop_front());
                end
                else
                    void'(angles_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles > WATCHDOG)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        quat_t q;
        rst_n       = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        gaps_on     = 1'b1;
        hold_off    = 1'b0;
        pending_q.push_back(make_quat(0, 0, 0, 0));
        pending_q.push_back(make_quat(16384, 0, 0, 0));
        pending_q.push_back(make_quat(-16384, 0, 0, 0));
        pending_q.push_back(make_quat(0, 16384, 0, 0));
        pending_q.push_back(make_quat(0, 0, 16384, 0));
        pending_q.push_back(make_quat(0, 0, 0, 16384));
        pending_q.push_back(make_quat(11585, 0, 11585, 0));
        pending_q.push_back(make_quat(11585, 0, -11585, 0));
        pending_q.push_back(make_quat(8192, 8192, 8192, -8192));
        pending_q.push_back(make_quat(8192, -8192, -8192, -8192));
        pending_q.push_back(make_quat(11500, 0, 11500, 0));
        pending_q.push_back(make_quat(11380, 0, 11380, 0));
        pending_q.push_back(make_quat(0, 11585, 0, 11585));
        pending_q.push_back(make_quat(0, 0, 0, -16384));
        pending_q.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_q.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_q.push_back(make_quat(-32768, 32767, -32768, 32767));
        pending_q.push_back(make_quat(11585, 0, 0, 11585));
        pending_q.push_back(make_quat(11585, 0, 0, -11585));
        pending_q.push_back(make_quat(16384, 16384, -16384, 16384));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_q.size() != 0)
            @(posedge clk);
        hold_off = 1'b1;
        while (angles_q.size() != 0 || start)
            @(posedge clk);
        hold_off = 1'b0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ($urandom_range(9))
                0:       q = quat_t'({$urandom(), $urandom()});
                1:       q = make_quat(comp_rand(), comp_rand(), comp_rand(), comp_rand());
                2, 3:    q = unit_quat(1'b1);
                default: q = unit_quat(1'b0);
            endcase
            pending_q.push_back(q);
            if (i == N_RANDOM - 80)
            begin
                while (pending_q.size() != 0)
                    @(posedge clk);
                gaps_on = 1'b0;
            end
        end
        while (pending_q.size() != 0 || start)
            @(posedge clk);
        while (angles_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatches == 0 && angles_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[filelist.f]
src/qte_pkg.sv
src/qte_front.sv
src/qte_isqrt.sv
src/qte_cordic.sv
src/quaternion_to_euler_heading.sv
test/testbench.sv
